>>> rtl/fss_pkg.sv
// Shared types, constants and character helpers for the fuzzy subsequence scorer.
`default_nettype none
package fss_pkg;

	localparam int QUERY_MAX    = 32;
	localparam int PATH_MAX_LEN = 4096;

	localparam int QLEN_W  = 6;
	localparam int QPOS_W  = 6;
	localparam int RUN_W   = 6;
	localparam int BPOS_W  = 12;
	localparam int SQ_W    = 12;
	localparam int SEG_W   = 15;
	localparam int BON_W   = 8;
	localparam int SCORE_W = 16;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 3;

	localparam logic [QLEN_W-1:0] QLEN_CAP     = QLEN_W'(QUERY_MAX);
	localparam logic [BPOS_W-1:0] BPOS_LAST    = BPOS_W'(PATH_MAX_LEN - 1);
	localparam logic [RUN_W-1:0]  RUN_SAT      = '1;
	localparam logic [5:0]        EARLY_WINDOW = 6'd40;
	localparam logic [BON_W-1:0]  WORD_BONUS   = 8'd4;

	typedef enum logic [CIDX_W-1:0] {
		REG_QUERY_LEN = 3'd0,
		REG_CHARS_0   = 3'd1,
		REG_CHARS_1   = 3'd2,
		REG_CHARS_2   = 3'd3,
		REG_CHARS_3   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                      matched;
		logic signed [SCORE_W-1:0] score;
	} fss_result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		is_sep = (c == 8'h2F) || (c == 8'h5C);
	endfunction

	function automatic logic is_word_mark(input logic [7:0] c);
		is_word_mark = (c == 8'h2F) || (c == 8'h5C) || (c == 8'h5F) ||
			(c == 8'h2D) || (c == 8'h2E);
	endfunction

endpackage
`default_nettype wire

>>> rtl/fss_score_engine.sv
// Per-path match state and the combinational scoring step for one path byte.
`default_nettype none
module fss_score_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [7:0]                     path_byte,
	input  wire logic                           path_last,
	input  wire logic [fss_pkg::QLEN_W-1:0]     query_len,
	input  wire logic [4*fss_pkg::CFG_W-1:0]    query_chars,
	output      fss_pkg::fss_result_t           result
);
	import fss_pkg::*;

	logic [QPOS_W-1:0] query_pos_q;
	logic [RUN_W-1:0]  run_length_q;
	logic [BPOS_W-1:0] byte_pos_q;
	logic [BPOS_W-1:0] first_hit_pos_q;
	logic              first_hit_seen_q;
	logic [7:0]        prev_byte_q;
	logic [SEG_W-1:0]  committed_q;
	logic [SEG_W-1:0]  seg_square_q;
	logic [BON_W-1:0]  seg_bonus_q;

	logic [7:0]        c;
	logic [QLEN_W-1:0] qlen;
	logic              active;
	logic [7:0]        qc;
	logic              hit;
	logic [RUN_W-1:0]  run_n;
	logic [SQ_W-1:0]   square;
	logic              seen_n;
	logic [BPOS_W-1:0] fpos_n;
	logic [QPOS_W-1:0] qpos_n;
	logic [SEG_W-1:0]  seg_square_n;
	logic [BON_W-1:0]  seg_bonus_n;
	logic [SEG_W-1:0]  committed_n;
	logic [SEG_W-1:0]  seg_square_k;
	logic [BON_W-1:0]  seg_bonus_k;
	logic [16:0]       base;
	logic [5:0]        early;
	logic [BPOS_W:0]   length;
	logic [16:0]       total;

	always_comb begin
		c      = to_lower(path_byte);
		qlen   = (query_len > QLEN_CAP) ? QLEN_CAP : query_len;
		active = query_pos_q < qlen;
		qc     = to_lower(query_chars[{query_pos_q[4:0], 3'b000} +: 8]);
		hit    = active && (c == qc);

		if (hit) begin
			run_n = (run_length_q == RUN_SAT) ? run_length_q : run_length_q + 1'b1;
		end else if (active) begin
			run_n = '0;
		end else begin
			run_n = run_length_q;
		end
		square = SQ_W'(run_n) * SQ_W'(run_n);

		seen_n = first_hit_seen_q || hit;
		fpos_n = (hit && !first_hit_seen_q) ? byte_pos_q : first_hit_pos_q;
		qpos_n = query_pos_q + QPOS_W'(hit);

		seg_square_n = seg_square_q + (hit ? SEG_W'(square) : '0);
		seg_bonus_n  = seg_bonus_q +
			((hit && (byte_pos_q == '0 || is_word_mark(prev_byte_q))) ? WORD_BONUS : '0);

		// A separator folds the open segment into the committed total at single weight.
		if (is_sep(c)) begin
			committed_n  = committed_q + seg_square_n + SEG_W'(seg_bonus_n);
			seg_square_k = '0;
			seg_bonus_k  = '0;
		end else begin
			committed_n  = committed_q;
			seg_square_k = seg_square_n;
			seg_bonus_k  = seg_bonus_n;
		end

		base = 17'(committed_n) + {1'b0, seg_square_k, 1'b0} + 17'(seg_bonus_k);
		if (!seen_n) begin
			early = EARLY_WINDOW;
		end else if (fpos_n < BPOS_W'(EARLY_WINDOW)) begin
			early = EARLY_WINDOW - fpos_n[5:0];
		end else begin
			early = '0;
		end
		length = {1'b0, byte_pos_q} + 1'b1;
		total  = base + 17'(early) - 17'(length[BPOS_W:4]);

		if (qlen == '0) begin
			result.matched = 1'b1;
			result.score   = '0;
		end else if (qpos_n >= qlen) begin
			result.matched = 1'b1;
			result.score   = total[SCORE_W-1:0];
		end else begin
			result.matched = 1'b0;
			result.score   = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_pos_q      <= '0;
			run_length_q     <= '0;
			byte_pos_q       <= '0;
			first_hit_pos_q  <= '0;
			first_hit_seen_q <= 1'b0;
			prev_byte_q      <= '0;
			committed_q      <= '0;
			seg_square_q     <= '0;
			seg_bonus_q      <= '0;
		end else if (step) begin
			if (path_last) begin
				query_pos_q      <= '0;
				run_length_q     <= '0;
				byte_pos_q       <= '0;
				first_hit_pos_q  <= '0;
				first_hit_seen_q <= 1'b0;
				prev_byte_q      <= '0;
				committed_q      <= '0;
				seg_square_q     <= '0;
				seg_bonus_q      <= '0;
			end else begin
				query_pos_q      <= qpos_n;
				run_length_q     <= run_n;
				first_hit_pos_q  <= fpos_n;
				first_hit_seen_q <= seen_n;
				prev_byte_q      <= c;
				committed_q      <= committed_n;
				seg_square_q     <= seg_square_k;
				seg_bonus_q      <= seg_bonus_k;
				if (byte_pos_q < BPOS_LAST) begin
					byte_pos_q <= byte_pos_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/fuzzy_subsequence_scorer_core.sv
// Top level of the fuzzy subsequence scorer: config registers, input stage, result register.
//
// Usage: load the query over the cfg port while idle (index 0 = query length,
// indexes 1..4 = eight query characters each, lowest character in the low
// byte), then stream path bytes on the slave channel, one byte per transfer,
// with s_tlast on the final byte of each path. Case is folded for A..Z.
// Only the final byte of a path produces a transfer on the master channel:
// m_tuser carries the match flag, m_tdata the signed score (-1 on a miss,
// 0 for an empty query).
// Throughput: one path byte per cycle while no final byte waits on a full
// result register; the scoring step between the input stage and the result
// register is combinational. A path's last byte is first registered in the
// input stage, then its result is loaded into the result register, which
// drives m_tvalid. Stall: while a result waits on m_tready the input stage
// still drains bytes that produce no result; a second final byte holds in
// the input stage, and s_tready drops only then.
// Reset: arst_n clears the query to empty, all per-path state and both valid
// flags; s_tready is high out of reset, since the input stage is then empty.
`default_nettype none
module fuzzy_subsequence_scorer_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave stream: path bytes
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] path_byte
	input  wire logic                           s_tlast,   // path_last
	// master stream: one result per path
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [15:0]                    m_tdata,   // [15:0] score (signed)
	output      logic                           m_tuser,   // [0] matched
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [fss_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [fss_pkg::CFG_W-1:0]      cfg_data
);
	import fss_pkg::*;

	logic [QLEN_W-1:0]     query_len_q;
	logic [4*CFG_W-1:0]    query_chars_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  advance;

	fss_result_t           result;
	logic                  out_valid_q;
	fss_result_t           out_q;

	// Configuration: write-only registers, unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_len_q   <= '0;
			query_chars_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUERY_LEN: query_len_q <= cfg_data[QLEN_W-1:0];
				REG_CHARS_0:   query_chars_q[0*CFG_W +: CFG_W] <= cfg_data;
				REG_CHARS_1:   query_chars_q[1*CFG_W +: CFG_W] <= cfg_data;
				REG_CHARS_2:   query_chars_q[2*CFG_W +: CFG_W] <= cfg_data;
				REG_CHARS_3:   query_chars_q[3*CFG_W +: CFG_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage unless it holds a final byte and the result
	// register is still full and not being taken.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	fss_score_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.path_byte   (byte_s1),
		.path_last   (last_s1),
		.query_len   (query_len_q),
		.query_chars (query_chars_q),
		.result      (result)
	);

	// Result register: load on a final byte, drop once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.score;
	assign m_tuser  = out_q.matched;

endmodule
`default_nettype wire
